>>> rtl/sttg_pkg.sv
// Shared types and constants of the square, triangle and sweep tone generator.
package sttg_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WAVE_MODE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_CHANGE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SAMPLE_COUNT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VOLUME       = 3'd4;

   typedef enum logic [1:0] {
      MODE_SQUARE   = 2'd0,
      MODE_TRIANGLE = 2'd1,
      MODE_SWEEP    = 2'd2
   } wave_mode_type;

   localparam int MODE_BITS        = 2;
   localparam int STEP_BITS        = 23;
   localparam int CHANGE_BITS      = 17;
   localparam int SAMPLE_CNT_BITS  = 20;
   localparam int VOLUME_BITS      = 16;

   // Wave values are Q2.22; the signed working width covers -1 .. +3.
   localparam int                    WAVE_BITS  = 25;
   localparam int                    FRAC_BITS  = 24;
   localparam logic signed [WAVE_BITS-1:0] WAVE_ONE   = 25'sd4194304;
   localparam logic signed [WAVE_BITS-1:0] WAVE_THREE = 25'sd12582912;
   localparam int                    MAG_BITS   = 23;

   localparam int PROD_BITS        = MAG_BITS + VOLUME_BITS;
   localparam int FULL_SCALE_SHIFT = 15;
   localparam int SCALED_BITS      = PROD_BITS + FULL_SCALE_SHIFT;
   localparam int SAMPLE_BITS      = 16;

   typedef struct packed {
      logic [MAG_BITS-1:0] mag;
      logic                neg;
      logic                last;
      logic                active;
   } wave_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
      logic                          active;
   } result_type;

endpackage

>>> rtl/sttg_scale.sv
// Two-stage volume scaler: magnitude times volume, then times 32767 and back to PCM.
module sttg_scale (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  sttg_pkg::wave_item_type               in_item,
   input  logic [sttg_pkg::VOLUME_BITS-1:0]      volume,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output sttg_pkg::result_type                  out_item
);
   import sttg_pkg::*;

   logic                   prod_valid_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic                   prod_neg_ff;
   logic                   prod_last_ff;
   logic                   prod_active_ff;
   logic                   prod_en;

   logic                   out_valid_ff;
   result_type             out_ff;
   result_type             out_in;
   logic                   out_en;

   logic [SCALED_BITS-1:0] scaled;
   logic [SAMPLE_BITS-1:0] mag_out;

   assign out_en   = !out_valid_ff || out_ready;
   assign prod_en  = !prod_valid_ff || out_en;
   assign in_ready = prod_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_en) begin
         prod_valid_ff <= in_valid;
      end
      if (prod_en && in_valid) begin
         prod_ff        <= PROD_BITS'(in_item.mag) * PROD_BITS'(volume);
         prod_neg_ff    <= in_item.neg;
         prod_last_ff   <= in_item.last;
         prod_active_ff <= in_item.active;
      end
   end

   // Times 32767 is a shift and a subtract; the 2^38 divide keeps the top bits.
   always_comb begin
      scaled  = {prod_ff, {FULL_SCALE_SHIFT{1'b0}}} - SCALED_BITS'(prod_ff);
      mag_out = scaled[SCALED_BITS-1 -: SAMPLE_BITS];
      out_in.sample = prod_neg_ff ? $signed(-mag_out) : $signed(mag_out);
      out_in.last   = prod_last_ff;
      out_in.active = prod_active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= prod_valid_ff;
      end
      if (out_en && prod_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule

>>> rtl/square_triangle_sweep_tone_generator_top.sv
// Top level of the square, triangle and sweep tone generator.
//
// Every transaction on the req_ channel is one audio tick and yields exactly one
// transaction on the rsp_ channel: a signed 16-bit sample, a flag for the final
// sample of the sound and a flag that the sound is still running. req_restart
// clears the phase and the sample index and reloads the phase increment from
// phase_step before that tick's sample is formed. Once sample_count samples
// have been produced the block returns zero samples until the next restart.
// Registers are written through the csr_ channel, which is always ready; write
// them only while no tick is in flight.
// The result passes three register stages: the wave register, the product register
// and the output register. One tick is accepted in every cycle while the receiver
// takes its results: the phase update is a single add in the first stage, followed
// by one multiplier stage and one shift-subtract stage.
// Each stage holds its item until the next one frees, so a stalled receiver
// fills the three stages before req_ready falls; nothing is dropped.
// Synchronous reset clears all registers, the phase state and the pipeline.
module square_triangle_sweep_tone_generator_top #(
   parameter int PHASE_BITS = 24,
   parameter int COUNT_BITS = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [sttg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                   rsp_last,
   output logic                                   rsp_active,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sttg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sttg_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import sttg_pkg::*;

   logic [MODE_BITS-1:0]          wave_mode_ff;
   logic [STEP_BITS-1:0]          phase_step_ff;
   logic [CHANGE_BITS-1:0]        step_change_ff;
   logic [SAMPLE_CNT_BITS-1:0]    sample_count_ff;
   logic [VOLUME_BITS-1:0]        volume_ff;

   logic [PHASE_BITS-1:0]         acc_ff;
   logic [PHASE_BITS-1:0]         inc_ff;
   logic [COUNT_BITS-1:0]         idx_ff;
   logic [PHASE_BITS-1:0]         acc_in;
   logic [PHASE_BITS-1:0]         inc_in;
   logic [COUNT_BITS-1:0]         idx_in;

   logic                          wave_valid_ff;
   wave_item_type                 wave_ff;
   wave_item_type                 wave_in;
   logic                          wave_en;
   logic                          scale_ready;
   logic                          req_fire;
   result_type                    result;

   logic [PHASE_BITS+31:0]        step_wide;
   logic [PHASE_BITS+31:0]        change_wide;
   logic [COUNT_BITS+19:0]        count_wide;
   logic [PHASE_BITS-1:0]         step_ext;
   logic [PHASE_BITS-1:0]         change_ext;
   logic [COUNT_BITS-1:0]         count_c;

   logic [PHASE_BITS-1:0]         acc_cur;
   logic [PHASE_BITS-1:0]         inc_cur;
   logic [COUNT_BITS-1:0]         idx_cur;
   logic                          active_c;
   wave_mode_type                 mode_c;
   logic [PHASE_BITS+FRAC_BITS-1:0] phase_wide;
   logic [FRAC_BITS-1:0]          quad;
   logic signed [WAVE_BITS-1:0]   tri_val;
   logic signed [WAVE_BITS-1:0]   tri_abs;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff    <= '0;
         phase_step_ff   <= '0;
         step_change_ff  <= '0;
         sample_count_ff <= '0;
         volume_ff       <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WAVE_MODE:    wave_mode_ff    <= csr_wdata[MODE_BITS-1:0];
            REG_PHASE_STEP:   phase_step_ff   <= csr_wdata[STEP_BITS-1:0];
            REG_STEP_CHANGE:  step_change_ff  <= csr_wdata[CHANGE_BITS-1:0];
            REG_SAMPLE_COUNT: sample_count_ff <= csr_wdata[SAMPLE_CNT_BITS-1:0];
            REG_VOLUME:       volume_ff       <= csr_wdata[VOLUME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Fit the fixed-width registers to the phase and count widths.
   always_comb begin
      step_wide   = {{(PHASE_BITS+9){1'b0}}, phase_step_ff};
      change_wide = {{(PHASE_BITS+15){step_change_ff[CHANGE_BITS-1]}}, step_change_ff};
      count_wide  = {{COUNT_BITS{1'b0}}, sample_count_ff};
      step_ext    = step_wide[PHASE_BITS-1:0];
      change_ext  = change_wide[PHASE_BITS-1:0];
      count_c     = count_wide[COUNT_BITS-1:0];
   end

   assign wave_en   = !wave_valid_ff || scale_ready;
   assign req_ready = wave_en;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      acc_cur  = req_restart ? '0 : acc_ff;
      inc_cur  = req_restart ? step_ext : inc_ff;
      idx_cur  = req_restart ? '0 : idx_ff;
      active_c = idx_cur < count_c;

      case (wave_mode_ff)
         MODE_TRIANGLE: mode_c = MODE_TRIANGLE;
         MODE_SWEEP:    mode_c = MODE_SWEEP;
         default:       mode_c = MODE_SQUARE;
      endcase

      // 4p as Q2.22: the top 24 bits of the phase padded with zeros.
      phase_wide = {acc_cur, {FRAC_BITS{1'b0}}};
      quad       = phase_wide[PHASE_BITS+FRAC_BITS-1 -: FRAC_BITS];
      if (!acc_cur[PHASE_BITS-1]) begin
         tri_val = $signed({1'b0, quad}) - WAVE_ONE;
      end else begin
         tri_val = WAVE_THREE - $signed({1'b0, quad});
      end
      tri_abs = tri_val[WAVE_BITS-1] ? -tri_val : tri_val;

      if (mode_c == MODE_TRIANGLE) begin
         wave_in.mag = tri_abs[MAG_BITS-1:0];
         wave_in.neg = tri_val[WAVE_BITS-1];
      end else begin
         wave_in.mag = WAVE_ONE[MAG_BITS-1:0];
         wave_in.neg = acc_cur[PHASE_BITS-1];
      end
      if (!active_c) begin
         wave_in.mag = '0;
      end
      wave_in.active = active_c;
      wave_in.last   = active_c && (idx_cur == count_c - 1'b1);

      acc_in = acc_cur;
      inc_in = inc_cur;
      idx_in = idx_cur;
      if (active_c) begin
         acc_in = acc_cur + inc_cur;
         idx_in = idx_cur + 1'b1;
         if (mode_c == MODE_SWEEP) begin
            inc_in = inc_cur + change_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         inc_ff        <= '0;
         idx_ff        <= '0;
         wave_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            acc_ff <= acc_in;
            inc_ff <= inc_in;
            idx_ff <= idx_in;
         end
         if (wave_en) begin
            wave_valid_ff <= req_valid;
         end
      end
      if (req_fire) begin
         wave_ff <= wave_in;
      end
   end

   sttg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wave_valid_ff),
      .in_ready  (scale_ready),
      .in_item   (wave_ff),
      .volume    (volume_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (result)
   );

   assign rsp_sample = result.sample;
   assign rsp_last   = result.last;
   assign rsp_active = result.active;

   // A finished sound gives silence and never flags a final sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_sample == '0 && !rsp_last)
      else $error("inactive result carries a nonzero sample or last flag");

   // The scaled magnitude never reaches full scale, so the most negative code is unused.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
      else $error("sample magnitude out of range");

   // A tick past the end of the sound leaves the phase where it was.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_restart && !active_c |=> $stable(acc_ff) && $stable(idx_ff))
      else $error("phase state moved on an inactive tick");

   // The final-sample flag only appears together with an active sample.
   assert property (@(posedge clock) disable iff (reset)
      wave_valid_ff && wave_ff.last |-> wave_ff.active)
      else $error("last flag without an active sample");

endmodule
